// File: rtl/core/max_box_iou_engine_assert.svh
// Assertion macros shared by the max box IoU engine modules.
`ifndef MAX_BOX_IOU_ENGINE_ASSERT_SVH
`define MAX_BOX_IOU_ENGINE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MBIOU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MBIOU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/mbiou_pkg.sv
// Shared constants, types and command/status structs of the max box IoU engine.
package mbiou_pkg;

	localparam int MAX_BOXES  = 64;
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;

	localparam int IDX_W  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNT_W  = $clog2(MAX_BOXES + 1);
	localparam int DIM_W  = COORD_BITS + 1;
	localparam int AREA_W = 2 * COORD_BITS + 1;
	localparam int UNI_W  = AREA_W + 1;
	localparam int PROD_W = AREA_W + UNI_W;
	localparam int QUO_W  = FRAC_BITS + 1;
	localparam int DCNT_W = $clog2(QUO_W);
	localparam int BOX_W  = 4 * COORD_BITS;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [1:0] kind_t;

	localparam kind_t KIND_CLEAR  = 2'd0;
	localparam kind_t KIND_APPEND = 2'd1;
	localparam kind_t KIND_QUERY  = 2'd2;

	typedef struct packed {
		coord_t left;
		coord_t top;
		coord_t right;
		coord_t bottom;
	} box_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK_A,
		ST_WALK_B,
		ST_DRAIN,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic clear;
		logic append;
		logic start;
		logic issue;
		logic div_start;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic walk_done;
		logic pipe_busy;
		logic div_last;
		logic out_full;
	} sts_t;

endpackage

// File: rtl/core/max_box_iou_engine.sv
// Top level of the max box IoU engine: best intersection over union against a box table.
// Clear and append requests produce no response.
// A query reads each stored box through the overlap pipeline, alternating a read state and
// a wait state, then runs a 17-step restoring divider; the response register lets a new
// request start before the result is taken.
// Reset (arst_n low, asynchronous) empties the table and clears all handshake state.
module max_box_iou_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  mbiou_pkg::kind_t               kind,
	input  mbiou_pkg::coord_t              left,
	input  mbiou_pkg::coord_t              top,
	input  mbiou_pkg::coord_t              right,
	input  mbiou_pkg::coord_t              bottom,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [mbiou_pkg::QUO_W-1:0]    best_overlap
);
	import mbiou_pkg::*;

	cmd_t cmd;
	sts_t sts;
	box_t req_box;

	assign req_box.left   = left;
	assign req_box.top    = top;
	assign req_box.right  = right;
	assign req_box.bottom = bottom;

	mbiou_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.kind     (kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	mbiou_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req_box     (req_box),
		.sts         (sts),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.best_overlap(best_overlap)
	);

endmodule

// File: rtl/core/mbiou_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mbiou_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/mbiou_ctrl.sv
// Controller state machine that sequences table updates, the query walk and the division.
`include "max_box_iou_engine_assert.svh"

module mbiou_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  mbiou_pkg::kind_t kind,
	input  mbiou_pkg::sts_t  sts,
	output mbiou_pkg::cmd_t  cmd
);
	import mbiou_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && kind == KIND_QUERY) begin
					state_d = ST_WALK_A;
				end
			end
			ST_WALK_A: begin
				state_d = sts.walk_done ? ST_DRAIN : ST_WALK_B;
			end
			ST_WALK_B: begin
				state_d = ST_WALK_A;
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!sts.out_full) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_CLEAR:  cmd.clear  = 1'b1;
						KIND_APPEND: cmd.append = 1'b1;
						KIND_QUERY:  cmd.start  = 1'b1;
						default:     cmd = '0;
					endcase
				end
			end
			ST_WALK_A: begin
				cmd.issue = !sts.walk_done;
			end
			ST_DRAIN: begin
				cmd.div_start = !sts.pipe_busy;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_FIN: begin
				cmd.load_out = !sts.out_full;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`MBIOU_ASSERT_NEXT(a_query_starts_walk, accept && kind == KIND_QUERY, state_q == ST_WALK_A, "query request did not start the walk")
	`MBIOU_ASSERT_NEXT(a_div_ends_in_fin, state_q == ST_DIV && sts.div_last, state_q == ST_FIN, "division did not finish")
	`MBIOU_ASSERT_NOW(a_wait_follows_issue, state_q == ST_WALK_B, $past(cmd.issue), "walk wait state without a read")

endmodule

// File: rtl/core/mbiou_dp.sv
// Datapath: box table, overlap pipeline, best-ratio tracking, divider and result register.
`include "max_box_iou_engine_assert.svh"

module mbiou_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mbiou_pkg::cmd_t                cmd,
	input  mbiou_pkg::box_t                req_box,
	output mbiou_pkg::sts_t                sts,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [mbiou_pkg::QUO_W-1:0]    best_overlap
);
	import mbiou_pkg::*;

	function automatic logic [DIM_W-1:0] span(input coord_t lo, input coord_t hi);
		return {1'b0, hi} - {1'b0, lo} + DIM_W'(1);
	endfunction

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	box_t              det_q;
	logic              ram_we;
	logic [BOX_W-1:0]  ram_rdata;
	box_t              ref_box;

	// Stage 1 is the registered RAM read.
	logic              v_s1;
	coord_t            ol, ot, orr, ob;
	logic              overlap;

	logic              v_s2;
	logic [DIM_W-1:0]  w_s2, h_s2, rw_s2, rh_s2, dw_s2, dh_s2;

	logic [2*DIM_W-1:0] inter_full, ar_full, ad_full;
	logic              v_s3;
	logic [AREA_W-1:0] inter_s3, ar_s3, ad_s3;

	logic              v_s4;
	logic [AREA_W-1:0] inter_s4;
	logic [UNI_W-1:0]  uni_s4;

	logic              v_s5;
	logic [AREA_W-1:0] inter_s5;
	logic [UNI_W-1:0]  uni_s5;
	logic [PROD_W-1:0] pnew_s5, pbest_s5;

	logic [AREA_W-1:0] best_i_q;
	logic [UNI_W-1:0]  best_u_q;

	logic [UNI_W:0]    rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              div_ge;
	logic [UNI_W:0]    div_diff;

	logic              rsp_valid_q;
	logic [QUO_W-1:0]  best_overlap_q;
	logic              pipe_busy;

	assign ram_we  = cmd.append && (count_q < CNT_W'(MAX_BOXES));
	assign ref_box = box_t'(ram_rdata);

	mbiou_ram #(
		.WIDTH(BOX_W),
		.DEPTH(MAX_BOXES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(req_box),
		.re   (cmd.issue),
		.raddr(idx_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (ram_we) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.start) begin
				idx_q <= '0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			det_q <= req_box;
		end
	end

	assign ol      = (ref_box.left > det_q.left) ? ref_box.left : det_q.left;
	assign ot      = (ref_box.top > det_q.top) ? ref_box.top : det_q.top;
	assign orr     = (ref_box.right < det_q.right) ? ref_box.right : det_q.right;
	assign ob      = (ref_box.bottom < det_q.bottom) ? ref_box.bottom : det_q.bottom;
	assign overlap = (orr >= ol) && (ob >= ot);

	assign inter_full = (2*DIM_W)'(w_s2) * (2*DIM_W)'(h_s2);
	assign ar_full    = (2*DIM_W)'(rw_s2) * (2*DIM_W)'(rh_s2);
	assign ad_full    = (2*DIM_W)'(dw_s2) * (2*DIM_W)'(dh_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1 && overlap;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		w_s2     <= span(ol, orr);
		h_s2     <= span(ot, ob);
		rw_s2    <= span(ref_box.left, ref_box.right);
		rh_s2    <= span(ref_box.top, ref_box.bottom);
		dw_s2    <= span(det_q.left, det_q.right);
		dh_s2    <= span(det_q.top, det_q.bottom);
		inter_s3 <= inter_full[AREA_W-1:0];
		ar_s3    <= ar_full[AREA_W-1:0];
		ad_s3    <= ad_full[AREA_W-1:0];
		inter_s4 <= inter_s3;
		uni_s4   <= UNI_W'(ar_s3) + UNI_W'(ad_s3) - UNI_W'(inter_s3);
		inter_s5 <= inter_s4;
		uni_s5   <= uni_s4;
		pnew_s5  <= PROD_W'(inter_s4) * PROD_W'(best_u_q);
		pbest_s5 <= PROD_W'(best_i_q) * PROD_W'(uni_s4);
	end

	// Candidates are issued only in ST_WALK_A, with a ST_WALK_B wait between issues, so the best ratio is updated
	// before the next candidate reaches the cross-multiplication stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_i_q <= '0;
			best_u_q <= UNI_W'(1);
		end else if (cmd.start) begin
			best_i_q <= '0;
			best_u_q <= UNI_W'(1);
		end else if (v_s5 && (pnew_s5 > pbest_s5)) begin
			best_i_q <= inter_s5;
			best_u_q <= uni_s5;
		end
	end

	assign div_ge   = rem_q >= {1'b0, best_u_q};
	assign div_diff = div_ge ? (rem_q - {1'b0, best_u_q}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_start) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= {1'b0, UNI_W'(best_i_q)};
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= {div_diff[UNI_W-1:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], div_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			best_overlap_q <= quo_q;
		end
	end

	assign pipe_busy     = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign sts.walk_done = (idx_q == count_q);
	assign sts.pipe_busy = pipe_busy;
	assign sts.div_last  = (dcnt_q == DCNT_W'(QUO_W - 1));
	assign sts.out_full  = rsp_valid_q;

	assign rsp_valid    = rsp_valid_q;
	assign best_overlap = best_overlap_q;

	`MBIOU_ASSERT_NOW(a_issue_in_table, cmd.issue, idx_q < count_q, "read beyond stored boxes")
	`MBIOU_ASSERT_NOW(a_best_ratio_le_one, 1'b1, best_i_q <= best_u_q, "best intersection above union")
	`MBIOU_ASSERT_NOW(a_load_into_empty, cmd.load_out, !rsp_valid_q, "result register overwritten")
	`MBIOU_ASSERT_NOW(a_div_after_drain, cmd.div_step, !pipe_busy, "division while the walk is still active")

endmodule
